// ----- hdl/sgnb_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, constants and latencies of the gaussian noise generator
package sgnb_pkg;

  localparam int unsigned UW = 32;   // uniform variate width
  localparam int unsigned SW = 32;   // scale and result width
  localparam int unsigned EW = 38;   // -2 ln u1 in q.32, always below 2^38
  localparam int unsigned RW = 31;   // radius width, q3.28
  localparam int unsigned TW = 34;   // cordic x / y width, q2.30 plus growth
  localparam int unsigned AW = 34;   // radius times trig, q.28

  localparam int unsigned LOG_STEPS    = 32;
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned CORDIC_STEPS = 32;

  localparam logic [31:0] LN2_Q32      = 32'hB17217F8;
  localparam logic [TW-1:0] CORDIC_START = TW'(32'h26DD3B6A);

  // atan(2^-i) in turns, q0.32
  localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // stage counts of each unit
  localparam int unsigned LOG_LAT     = LOG_STEPS + 3;
  localparam int unsigned SQRT_LAT    = SQRT_STEPS;
  localparam int unsigned CORDIC_LAT  = CORDIC_STEPS + 2;
  localparam int unsigned SCALE_LAT   = 4;
  localparam int unsigned ANGLE_DELAY = LOG_LAT + SQRT_LAT - CORDIC_LAT;
  localparam int unsigned SIDE_DELAY  = LOG_LAT + SQRT_LAT;
  localparam int unsigned TOTAL_LAT   = SIDE_DELAY + SCALE_LAT;

endpackage

// ----- hdl/sgnb_in_if.sv -----
`timescale 1ns / 1ps
// input channel: uniform pair, scale and end-of-array mark
interface sgnb_in_if;
  import sgnb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [UW-1:0]        uniform_first;
  logic [UW-1:0]        uniform_second;
  logic signed [SW-1:0] point_scale;
  logic                 last_in;

  modport source (output valid, uniform_first, uniform_second, point_scale, last_in,
                  input ready);
  modport sink   (input valid, uniform_first, uniform_second, point_scale, last_in,
                  output ready);
endinterface

// ----- hdl/sgnb_out_if.sv -----
`timescale 1ns / 1ps
// output channel: complex noise sample with saturation flag
interface sgnb_out_if;
  import sgnb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] noise_real;
  logic signed [SW-1:0] noise_imag;
  logic                 saturated;
  logic                 last_out;

  modport source (output valid, noise_real, noise_imag, saturated, last_out, input ready);
  modport sink   (input valid, noise_real, noise_imag, saturated, last_out, output ready);
endinterface

// ----- hdl/sgnb_delay.sv -----
`timescale 1ns / 1ps
// enabled shift line for side data
module sgnb_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);
  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];
endmodule

// ----- hdl/sgnb_log.sv -----
`timescale 1ns / 1ps
// pipelined -2 ln(u1) by normalise, repeated squaring and ln 2 scaling
module sgnb_log (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [sgnb_pkg::UW-1:0] u1_i,
  output logic [sgnb_pkg::EW-1:0] e_o
);
  import sgnb_pkg::*;

  logic [4:0]  n_d;
  logic [31:0] x_q    [LOG_STEPS+1];
  logic [31:0] f_q    [LOG_STEPS+1];
  logic [4:0]  n_q    [LOG_STEPS+1];
  logic        zero_q [LOG_STEPS+1];
  logic [37:0] lw;
  logic [63:0] plo_q;
  logic [37:0] phi_q;
  logic        zero_m_q;
  logic [64:0] plo_rnd;
  logic [39:0] e_full;
  logic [EW-1:0] e_q;

  // leading zero count
  always_comb begin
    n_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (u1_i[i]) n_d = 5'(31 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= u1_i << n_d;
      f_q[0]    <= '0;
      n_q[0]    <= n_d;
      zero_q[0] <= (u1_i == '0);
    end
  end

  // one fraction bit per stage, msb first
  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    logic [31:0] fn;
    assign sq = 64'(x_q[k]) * 64'(x_q[k]);
    assign t  = sq[63:31];
    always_comb begin
      fn = f_q[k];
      fn[LOG_STEPS-1-k] = t[32];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]    <= t[32] ? t[32:1] : t[31:0];
        f_q[k+1]    <= fn;
        n_q[k+1]    <= n_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // -log2(u1) in q.32
  assign lw = {6'(n_q[LOG_STEPS]) + 6'd1, 32'b0} - {6'b0, f_q[LOG_STEPS]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q    <= 64'(lw[31:0]) * 64'(LN2_Q32);
      phi_q    <= 38'(lw[37:32]) * 38'(LN2_Q32);
      zero_m_q <= zero_q[LOG_STEPS];
    end
  end

  assign plo_rnd = 65'(plo_q) + 65'(64'h4000_0000);
  assign e_full  = 40'({phi_q, 1'b0}) + 40'(plo_rnd[64:31]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= zero_m_q ? '0 : e_full[EW-1:0];
    end
  end

  assign e_o = e_q;
endmodule

// ----- hdl/sgnb_sqrt.sv -----
`timescale 1ns / 1ps
// pipelined integer square root, one result bit per stage
module sgnb_sqrt (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [sgnb_pkg::EW-1:0] e_i,
  output logic [sgnb_pkg::RW-1:0] r_o
);
  import sgnb_pkg::*;

  logic [63:0] v_q   [SQRT_STEPS];
  logic [63:0] res_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_st
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] vin, rin, trial;
    if (j == 0) begin : g_first
      assign vin = 64'({e_i, 24'b0});
      assign rin = '0;
    end else begin : g_next
      assign vin = v_q[j-1];
      assign rin = res_q[j-1];
    end
    assign trial = rin + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (vin >= trial) begin
          v_q[j]   <= vin - trial;
          res_q[j] <= (rin >> 1) + BIT;
        end else begin
          v_q[j]   <= vin;
          res_q[j] <= rin >> 1;
        end
      end
    end
  end

  assign r_o = res_q[SQRT_STEPS-1][RW-1:0];
endmodule

// ----- hdl/sgnb_cordic.sv -----
`timescale 1ns / 1ps
// pipelined rotation cordic on the phase in turns, with quadrant fold
module sgnb_cordic (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [sgnb_pkg::UW-1:0]        u2_i,
  output logic signed [sgnb_pkg::TW-1:0] c_o,
  output logic signed [sgnb_pkg::TW-1:0] s_o
);
  import sgnb_pkg::*;

  logic [31:0]          sum_d;
  logic [1:0]           q_d;
  logic signed [TW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [TW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [31:0]   z_q [CORDIC_STEPS+1];
  logic [1:0]           q_q [CORDIC_STEPS+1];
  logic signed [TW-1:0] c_q, s_q, xf, yf;

  // nearest quarter turn and signed residual
  assign sum_d = u2_i + 32'h2000_0000;
  assign q_d   = sum_d[31:30];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_START;
      y_q[0] <= '0;
      z_q[0] <= $signed(u2_i - {q_d, 30'b0});
      q_q[0] <= q_d;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [TW-1:0] xs, ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][31]) begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - $signed(TURN_ATAN[k]);
        end else begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + $signed(TURN_ATAN[k]);
        end
        q_q[k+1] <= q_q[k];
      end
    end
  end

  assign xf = x_q[CORDIC_STEPS];
  assign yf = y_q[CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (q_q[CORDIC_STEPS])
        2'd0: begin c_q <= xf;  s_q <= yf;  end
        2'd1: begin c_q <= -yf; s_q <= xf;  end
        2'd2: begin c_q <= -xf; s_q <= -yf; end
        2'd3: begin c_q <= yf;  s_q <= -xf; end
        default: begin c_q <= xf; s_q <= yf; end
      endcase
    end
  end

  assign c_o = c_q;
  assign s_o = s_q;
endmodule

// ----- hdl/sgnb_scale.sv -----
`timescale 1ns / 1ps
// radius times trig, times scale, rounding and saturation
module sgnb_scale (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [sgnb_pkg::RW-1:0]        r_i,
  input  logic signed [sgnb_pkg::TW-1:0] c_i,
  input  logic signed [sgnb_pkg::TW-1:0] s_i,
  input  logic signed [sgnb_pkg::SW-1:0] scale_i,
  input  logic                           last_i,
  output logic signed [sgnb_pkg::SW-1:0] real_o,
  output logic signed [sgnb_pkg::SW-1:0] imag_o,
  output logic                           sat_o,
  output logic                           last_o
);
  import sgnb_pkg::*;

  logic signed [31:0]   rs;
  logic signed [65:0]   pc_q, ps_q, rc, rsn;
  logic signed [AW-1:0] ac_q, as_q;
  logic signed [65:0]   qc_q, qs_q, vc, vs;
  logic signed [SW-1:0] sc1_q, sc2_q;
  logic [3:0]           last_q;
  logic signed [SW-1:0] re_q, im_q, re_d, im_d;
  logic                 sre, sim, sat_q;

  function automatic logic signed [SW:0] clip(input logic signed [37:0] v);
    logic [6:0] top;
    top = v[37:31];
    if (!v[37] && top != 7'h00) return {1'b1, 32'h7FFF_FFFF};
    if (v[37] && top != 7'h7F)  return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  assign rs = $signed({1'b0, r_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q   <= 66'(rs) * 66'(c_i);
      ps_q   <= 66'(rs) * 66'(s_i);
      sc1_q  <= scale_i;
      last_q <= {last_q[2:0], last_i};
    end
  end

  // q.28 after rounding off 30 bits
  assign rc  = pc_q + 66'sd536870912;
  assign rsn = ps_q + 66'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q  <= rc[63:30];
      as_q  <= rsn[63:30];
      sc2_q <= sc1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qc_q <= 66'(sc2_q) * 66'(ac_q);
      qs_q <= 66'(sc2_q) * 66'(as_q);
    end
  end

  assign vc = qc_q + 66'sd134217728;
  assign vs = qs_q + 66'sd134217728;
  assign {sre, re_d} = clip(vc[65:28]);
  assign {sim, im_d} = clip(vs[65:28]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q  <= re_d;
      im_q  <= im_d;
      sat_q <= sre | sim;
    end
  end

  assign real_o = re_q;
  assign imag_o = im_q;
  assign sat_o  = sat_q;
  assign last_o = last_q[3];
endmodule

// ----- hdl/scaled_gaussian_noise_box_muller.sv -----
`timescale 1ns / 1ps
// top level of the box-muller complex gaussian noise generator
// usage:
//   in_i carries one point per transaction: u1 and u2 (unsigned q0.32),
//   a signed q16.16 scale and an end-of-array mark; out_o returns one
//   complex sample per point (q16.16 real and imaginary, saturating), a
//   clip flag and the copied mark, in input order
//   a result on out_o passes through the 32-stage squaring log, the
//   32-stage square root and the final multiply and round stages; the
//   cordic runs beside the square root
//   throughput is one transaction per cycle unless out_o stalls; the
//   whole pipe advances together, the last stage being the output register
//   when the receiver stalls with a result waiting, the pipe freezes and
//   in_i.ready drops; while the output register is empty, input is still
//   taken, but a bubble inside the pipe keeps its place
//   reset clears only the valid bits, so out_o.valid is low after reset
//   and data registers hold whatever they held
//   a u1 code of zero yields a zero sample
module scaled_gaussian_noise_box_muller (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgnb_in_if.sink    in_i,
  sgnb_out_if.source out_o
);
  import sgnb_pkg::*;

  logic                 en;
  logic [TOTAL_LAT-1:0] vld_q;
  logic [EW-1:0]        e_w;
  logic [RW-1:0]        r_w;
  logic [UW-1:0]        u2_dly;
  logic signed [TW-1:0] c_w, s_w;
  logic [SW:0]          side_dly;

  // whole pipe moves when the output slot is free or being emptied
  assign en       = !vld_q[TOTAL_LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], in_i.valid};
    end
  end

  // radius path
  sgnb_log u_log (
    .clk_i (clk_i),
    .en_i  (en),
    .u1_i  (in_i.uniform_first),
    .e_o   (e_w)
  );

  sgnb_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .e_i   (e_w),
    .r_o   (r_w)
  );

  // angle path, held back so the cordic ends with the square root
  sgnb_delay #(.WIDTH(UW), .DEPTH(ANGLE_DELAY)) u_angle_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (in_i.uniform_second),
    .q_o   (u2_dly)
  );

  sgnb_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .u2_i  (u2_dly),
    .c_o   (c_w),
    .s_o   (s_w)
  );

  // scale and end mark ride alongside to the product stages
  sgnb_delay #(.WIDTH(SW + 1), .DEPTH(SIDE_DELAY)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({in_i.last_in, in_i.point_scale}),
    .q_o   (side_dly)
  );

  sgnb_scale u_scale (
    .clk_i   (clk_i),
    .en_i    (en),
    .r_i     (r_w),
    .c_i     (c_w),
    .s_i     (s_w),
    .scale_i ($signed(side_dly[SW-1:0])),
    .last_i  (side_dly[SW]),
    .real_o  (out_o.noise_real),
    .imag_o  (out_o.noise_imag),
    .sat_o   (out_o.saturated),
    .last_o  (out_o.last_out)
  );

  assign out_o.valid = vld_q[TOTAL_LAT-1];
endmodule

// ----- test/scaled_gaussian_noise_box_muller_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the box-muller gaussian noise generator
module scaled_gaussian_noise_box_muller_test;
  import sgnb_pkg::*;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 sat;
    logic                 last;
  } noise_sample_t;

  localparam longint STEP_ANGLE [CORDIC_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000
  };

  class noise_scoreboard;
    noise_sample_t pending_q[$];
    int            errors;
    int            checked;
    int            clipped;
    int            zero_u1;

    // -2 ln u1 in q.32 via squaring log2
    function bit [63:0] minus_two_ln(bit [31:0] u1);
      int        lz;
      bit [63:0] x, frac, lw, lo, hi;
      lz = 0;
      while (lz < 31 && u1[31-lz] == 1'b0) lz++;
      x = 64'(u1) << lz;
      frac = 0;
      for (int i = 31; i >= 0; i--) begin
        x = (x * x) >> 31;
        if (x >= 64'h1_0000_0000) begin
          frac[i] = 1'b1;
          x = x >> 1;
        end
      end
      lw = (64'(lz + 1) << 32) - frac;
      hi = lw >> 32;
      lo = lw & 64'hFFFF_FFFF;
      return ((hi * 64'(LN2_Q32)) << 1) + ((lo * 64'(LN2_Q32) + (64'd1 << 30)) >> 31);
    endfunction

    function bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint clip_part(longint scale, longint radius, longint trig, ref bit sat);
      longint a, v;
      a = (radius * trig + (64'sd1 <<< 29)) >>> 30;
      v = (scale * a + (64'sd1 <<< 27)) >>> 28;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        sat = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        sat = 1'b1;
      end
      return v;
    endfunction

    function noise_sample_t gaussian_point(bit [31:0] u1, bit [31:0] u2,
                                           bit signed [31:0] scale, bit last);
      noise_sample_t s;
      longint        radius, x, y, nx, z, c, sn;
      bit [1:0]      quad;
      bit [31:0]     resid;
      bit            sat;
      radius = 0;
      sat = 1'b0;
      if (u1 != 0) radius = longint'(root_floor(minus_two_ln(u1) << 24));
      quad = 2'((u2 + 32'h2000_0000) >> 30);
      resid = u2 - (32'(quad) << 30);
      z = longint'($signed(resid));
      x = 64'h26DD3B6A;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - STEP_ANGLE[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + STEP_ANGLE[i];
        end
        x = nx;
      end
      case (quad)
        2'd0: begin c = x;  sn = y;  end
        2'd1: begin c = -y; sn = x;  end
        2'd2: begin c = -x; sn = -y; end
        default: begin c = y; sn = -x; end
      endcase
      s.re   = 32'(clip_part(longint'(scale), radius, c, sat));
      s.im   = 32'(clip_part(longint'(scale), radius, sn, sat));
      s.sat  = sat;
      s.last = last;
      return s;
    endfunction

    function void note_point(bit [31:0] u1, bit [31:0] u2, bit signed [31:0] scale, bit last);
      noise_sample_t s;
      s = gaussian_point(u1, u2, scale, last);
      if (s.sat) clipped++;
      if (u1 == 0) zero_u1++;
      pending_q.push_back(s);
    endfunction

    function void check_sample(noise_sample_t got);
      noise_sample_t want;
      checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected sample re=%h im=%h sat=%b last=%b",
                 $time, got.re, got.im, got.sat, got.last);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.re !== want.re) begin
        $display("%0t: noise_real expected %h actual %h", $time, want.re, got.re);
        errors++;
      end
      if (got.im !== want.im) begin
        $display("%0t: noise_imag expected %h actual %h", $time, want.im, got.im);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_out expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sgnb_in_if  in_ch ();
  sgnb_out_if out_ch ();

  scaled_gaussian_noise_box_muller DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  noise_scoreboard board = new();

  int  sent;
  int  received;
  bit  stimulus_done;

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.uniform_first  = '0;
    in_ch.uniform_second = '0;
    in_ch.point_scale    = '0;
    in_ch.last_in        = 1'b0;
    out_ch.ready         = 1'b0;
  end

  // gap length: mostly short, now and then long
  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // both channels are sampled at the falling edge, clear of the
  // rising edge at which the transaction takes place
  always @(negedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      board.note_point(in_ch.uniform_first, in_ch.uniform_second,
                       in_ch.point_scale, in_ch.last_in);
      sent++;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_sample({out_ch.noise_real, out_ch.noise_imag,
                          out_ch.saturated, out_ch.last_out});
      received++;
    end
  end

  // offer one point from the current rising edge, hold it until the
  // transaction completes; returns at the edge that took it
  task automatic send_point(bit [31:0] u1, bit [31:0] u2, bit [31:0] scale, bit last);
    bit taken;
    in_ch.valid          <= 1'b1;
    in_ch.uniform_first  <= u1;
    in_ch.uniform_second <= u2;
    in_ch.point_scale    <= scale;
    in_ch.last_in        <= last;
    do begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end while (!taken);
    // valid is lowered at the next drive only when a gap follows
  endtask

  task automatic idle_input(int cycles);
    if (cycles == 0) return;
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // u1 spread over all magnitudes so every leading-zero count turns up
  function automatic bit [31:0] random_u1();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return 32'd0;
    if (p < 40) return $urandom() >> $urandom_range(0, 31);
    return $urandom();
  endfunction

  function automatic bit [31:0] random_scale();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    if (p < 85) return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    return $urandom();
  endfunction

  task automatic directed_points();
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0); // zero u1
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0); // largest radius, clips
    send_point(32'h0000_0001, 32'h4000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0001, 32'h8000_0000, 32'h0001_0000, 1'b1);
    send_point(32'hFFFF_FFFF, 32'hC000_0000, 32'h0001_0000, 1'b0); // smallest radius
    send_point(32'h8000_0000, 32'h2000_0000, 32'h0001_0000, 1'b0); // quadrant edges
    send_point(32'h8000_0000, 32'h1FFF_FFFF, 32'h0001_0000, 1'b0);
    send_point(32'h8000_0000, 32'h6000_0000, 32'hFFFF_0000, 1'b0);
    send_point(32'h8000_0000, 32'hA000_0000, 32'h0000_0000, 1'b1);
    send_point(32'h8000_0000, 32'hE000_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h4000_0000, 32'hDFFF_FFFF, 32'h0000_0001, 1'b0);
    send_point(32'h0000_0100, 32'h1234_5678, 32'h0100_0000, 1'b0); // large scale, still below the clip limit
    send_point(32'h0000_0100, 32'h9ABC_DEF0, 32'hFF00_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h5555_5555, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h0000_FFFF, 32'hAAAA_AAAA, 32'h8000_0001, 1'b1);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
  endtask

  // sender
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    directed_points();
    for (int n = 0; n < 650; n++) begin
      idle_input(gap_length());
      send_point(random_u1(), $urandom(), random_scale(), $urandom_range(0, 7) == 0);
    end
    in_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off so the pipe fills and
  // in_i.ready has to drop while the sender keeps offering
  initial begin
    int  hold;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && received >= 120) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      hold = gap_length();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // end of run
  initial begin
    wait (stimulus_done);
    wait (board.pending_q.size() == 0);
    repeat (TOTAL_LAT + 30) @(posedge clk_i);
    $display("%0d points sent, %0d samples checked, %0d clipped, %0d with zero u1",
             sent, board.checked, board.clipped, board.zero_u1);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS scaled_gaussian_noise_box_muller");
    end else begin
      $display("FAIL scaled_gaussian_noise_box_muller");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d samples outstanding", board.pending_q.size());
    $display("FAIL scaled_gaussian_noise_box_muller");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sgnb_pkg.sv
hdl/sgnb_in_if.sv
hdl/sgnb_out_if.sv
hdl/sgnb_delay.sv
hdl/sgnb_log.sv
hdl/sgnb_sqrt.sv
hdl/sgnb_cordic.sv
hdl/sgnb_scale.sv
hdl/scaled_gaussian_noise_box_muller.sv
test/scaled_gaussian_noise_box_muller_test.sv
